// ----- rtl/pixel_gradient_features_defines.svh -----
// Assertion macros shared by the pixel gradient feature RTL
`ifndef PIXEL_GRADIENT_FEATURES_DEFINES_SVH
`define PIXEL_GRADIENT_FEATURES_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PGF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define PGF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/pgf_pkg.sv -----
// Package for the pixel gradient feature block: types, codes and constants
package pgf_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
  localparam logic [2:0] REG_CLAMP_LOW   = 3'd1;
  localparam logic [2:0] REG_CLAMP_HIGH  = 3'd2;
  localparam logic [2:0] REG_FIRST_GAIN  = 3'd3;
  localparam logic [2:0] REG_ABS_ENABLE  = 3'd4;

  localparam int CFG_DW = 11;

  // Gray conversion weights (Q14)
  localparam logic [12:0] W_RED   = 13'd4899;
  localparam logic [13:0] W_GREEN = 14'd9617;
  localparam logic [10:0] W_BLUE  = 11'd1868;
  localparam logic [13:0] GRAY_RND = 14'd8192;

  // Square root: 21-bit operand, 11 result bits
  localparam int SQ_W = 21;
  localparam logic [3:0] ROOT_TOP = 4'd10;

  // Read address select of the line buffers
  typedef enum logic [1:0] {
    ADDR_CTR   = 2'd0,
    ADDR_RIGHT = 2'd1,
    ADDR_LEFT  = 2'd2
  } addr_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    addr_sel_t addr_sel;
    logic      cap_ctr;
    logic      cap_right;
    logic      calc;
    logic      square;
    logic      root_step;
  } pgf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;
    logic emit;
    logic root_done;
  } pgf_status_t;

endpackage

// ----- rtl/pixel_gradient_features.sv -----
// Top level of the pixel gradient feature block
// Takes raster-order RGB pixels (one per transaction), converts each to a clamped
// gray value and gives, one row late, the gray value, first and second differences
// and the gradient magnitude of each pixel, with replicated borders. Flush
// transactions drive out the last row; the final one is marked frame_last. A pixel
// transaction makes three reads through the shared line-buffer read address;
// outside the first row, and for a flush, the 11 steps of the bit-serial square
// root follow, and the result then waits out any output stall. Only one
// transaction is in flight; a flush with nothing pending is absorbed with
// no result.
`include "pixel_gradient_features_defines.svh"

module pixel_gradient_features import pgf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic               in_flush,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_gray_out,
  output logic signed [10:0] out_grad_x,
  output logic signed [10:0] out_grad_y,
  output logic signed [9:0]  out_grad_xx,
  output logic signed [9:0]  out_grad_yy,
  output logic [10:0]        out_magnitude,
  output logic               out_frame_last
);

  pgf_cmd_t    cmd;
  pgf_status_t status;

  pgf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  pgf_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_flush       (in_flush),
    .cmd            (cmd),
    .status         (status),
    .out_gray_out   (out_gray_out),
    .out_grad_x     (out_grad_x),
    .out_grad_y     (out_grad_y),
    .out_grad_xx    (out_grad_xx),
    .out_grad_yy    (out_grad_yy),
    .out_magnitude  (out_magnitude),
    .out_frame_last (out_frame_last)
  );

  // One transaction in flight at a time
  `PGF_ASSERT_NOW(a_no_accept_with_result, clk, rst_n, in_valid && !in_stall, !out_valid, "input accepted while a result is pending")
  // Magnitude stays within its bound for the largest first differences
  `PGF_ASSERT_NOW(a_mag_range, clk, rst_n, out_valid, out_magnitude <= 11'd1443, "magnitude out of range")
  // A taken result returns the block to idle
  `PGF_ASSERT_NEXT(a_idle_after_out, clk, rst_n, out_valid && !out_stall, !out_valid && !in_stall, "block not idle after result taken")

endmodule

// ----- rtl/pgf_ctrl.sv -----
// Controller state machine of the pixel gradient feature block
module pgf_ctrl import pgf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output pgf_cmd_t    cmd,
  input  pgf_status_t status
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RDC   = 8'b0000_0010,
    S_RDR   = 8'b0000_0100,
    S_RDL   = 8'b0000_1000,
    S_CALC  = 8'b0001_0000,
    S_SQR   = 8'b0010_0000,
    S_ROOT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.addr_sel  = ADDR_CTR;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!status.skip) state_nxt = S_RDC;
        end
      end
      S_RDC: begin
        state_nxt = S_RDR;
      end
      S_RDR: begin
        cmd.cap_ctr  = 1'b1;
        cmd.addr_sel = ADDR_RIGHT;
        state_nxt    = S_RDL;
      end
      S_RDL: begin
        cmd.cap_right = 1'b1;
        cmd.addr_sel  = ADDR_LEFT;
        state_nxt     = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = status.emit ? S_SQR : S_IDLE;
      end
      S_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- rtl/pgf_datapath.sv -----
// Datapath: configuration, counters, line buffers, differences and square root
module pgf_datapath import pgf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic               in_flush,
  input  pgf_cmd_t           cmd,
  output pgf_status_t        status,
  output logic [7:0]         out_gray_out,
  output logic signed [10:0] out_grad_x,
  output logic signed [10:0] out_grad_y,
  output logic signed [9:0]  out_grad_xx,
  output logic signed [9:0]  out_grad_yy,
  output logic [10:0]        out_magnitude,
  output logic               out_frame_last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] MINW = WW'(3);

  // Configuration registers
  logic [10:0] frame_width_r;
  logic [7:0]  clamp_low_r, clamp_high_r;
  logic [2:0]  first_gain_r;
  logic        abs_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= 11'd640;
      clamp_low_r   <= 8'd0;
      clamp_high_r  <= 8'd255;
      first_gain_r  <= 3'd1;
      abs_enable_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: frame_width_r <= cfg_data;
        REG_CLAMP_LOW:   clamp_low_r   <= cfg_data[7:0];
        REG_CLAMP_HIGH:  clamp_high_r  <= cfg_data[7:0];
        REG_FIRST_GAIN:  first_gain_r  <= cfg_data[2:0];
        REG_ABS_ENABLE:  abs_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Width in use, clamped into 3..MAX_WIDTH
  logic [WW-1:0] w_eff;
  always_comb begin
    if (frame_width_r < 11'd3)                 w_eff = MINW;
    else if (32'(frame_width_r) > MAX_WIDTH)   w_eff = MAXW;
    else                                        w_eff = WW'(frame_width_r);
  end

  // Frame position state
  logic [WW-1:0] col_r, col_nxt;
  logic [1:0]    row_r, row_nxt;
  logic          drain_r, drain_nxt;

  // Per-transaction registers
  logic [WW-1:0] c_r, c_nxt;
  logic          flush_r, emit_r, emit_nxt, use_abv_r, use_abv_nxt;
  logic          last_r, last_nxt, has_left_r, has_left_nxt, has_right_r, has_right_nxt;
  logic          skip;
  logic [7:0]    red_r, green_r, blue_r;

  // Accept-time decisions
  always_comb begin
    logic [WW-1:0] col_e, c0;
    logic [1:0]    rb;
    logic [WW:0]   c_inc;
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    skip      = 1'b0;
    last_nxt  = 1'b0;
    col_e     = '0;
    rb        = '0;
    if (in_flush) begin
      skip  = !drain_r && ((row_r == 2'd0) || ((col_r != '0) && (col_r < w_eff)));
      c0    = drain_r ? col_r : '0;
      c_nxt = (c0 >= w_eff) ? w_eff - WW'(1) : c0;
      c_inc = {1'b0, c_nxt} + (WW+1)'(1);
      last_nxt    = (c_inc >= {1'b0, w_eff});
      emit_nxt    = 1'b1;
      use_abv_nxt = (row_r == 2'd2);
      if (!skip) begin
        if (last_nxt) begin
          row_nxt   = '0;
          col_nxt   = '0;
          drain_nxt = 1'b0;
        end else begin
          drain_nxt = 1'b1;
          col_nxt   = c_inc[WW-1:0];
        end
      end
    end else begin
      col_e = drain_r ? '0 : col_r;
      rb    = drain_r ? 2'd0 : row_r;
      c0    = col_e;
      c_nxt = (col_e < w_eff) ? col_e : '0;
      c_inc = {1'b0, c_nxt} + (WW+1)'(1);
      emit_nxt    = (rb != 2'd0);
      use_abv_nxt = (rb == 2'd2);
      drain_nxt   = 1'b0;
      if (c_inc >= {1'b0, w_eff}) begin
        col_nxt = '0;
        row_nxt = (rb == 2'd2) ? rb : rb + 2'd1;
      end else begin
        col_nxt = c_inc[WW-1:0];
        row_nxt = rb;
      end
    end
    has_left_nxt  = (c_nxt != '0);
    has_right_nxt = (c_inc < {1'b0, w_eff});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= 1'b0;
    end else if (cmd.accept && !skip) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c_r         <= c_nxt;
      flush_r     <= in_flush;
      emit_r      <= emit_nxt;
      use_abv_r   <= use_abv_nxt;
      last_r      <= last_nxt;
      has_left_r  <= has_left_nxt;
      has_right_r <= has_right_nxt;
      red_r       <= in_red;
      green_r     <= in_green;
      blue_r      <= in_blue;
    end
  end

  // Line buffers, one registered read port each
  logic [7:0]    line_prev  [MAX_WIDTH];
  logic [7:0]    line_prev2 [MAX_WIDTH];
  logic [7:0]    prev_q, prev2_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [7:0]    ctr_r, abv_r, rgt_r, gray_r, left_centre_r;

  always_comb begin
    case (cmd.addr_sel)
      ADDR_RIGHT: rd_addr = c_r[AW-1:0] + AW'(1);
      ADDR_LEFT:  rd_addr = c_r[AW-1:0] - AW'(1);
      default:    rd_addr = c_r[AW-1:0];
    endcase
  end

  assign wr_en = cmd.calc && !flush_r;

  always_ff @(posedge clk) begin
    prev_q  <= line_prev[rd_addr];
    prev2_q <= line_prev2[rd_addr];
    if (wr_en) begin
      line_prev[c_r[AW-1:0]]  <= gray_r;
      line_prev2[c_r[AW-1:0]] <= ctr_r;
    end
  end

  // Gray conversion and clamp
  logic [21:0] gray_sum;
  logic [7:0]  gray_raw, gray_clamped;
  always_comb begin
    gray_sum = 22'(W_RED) * 22'(red_r) + 22'(W_GREEN) * 22'(green_r)
             + 22'(W_BLUE) * 22'(blue_r) + 22'(GRAY_RND);
    gray_raw = gray_sum[21:14];
    if (gray_raw < clamp_low_r)       gray_clamped = clamp_low_r;
    else if (gray_raw > clamp_high_r) gray_clamped = clamp_high_r;
    else                              gray_clamped = gray_raw;
  end

  // Neighbour capture
  always_ff @(posedge clk) begin
    if (cmd.cap_ctr) begin
      ctr_r  <= prev_q;
      abv_r  <= prev2_q;
      gray_r <= gray_clamped;
    end
    if (cmd.cap_right) rgt_r <= prev_q;
    if (!rst_n)     left_centre_r <= '0;
    else if (wr_en) left_centre_r <= ctr_r;
  end

  // Differences
  logic [7:0]         lft, rgt, abv, blw;
  logic [3:0]         gain;
  logic signed [13:0] gx_full, gy_full;
  logic signed [10:0] gxx_full, gyy_full;
  logic signed [10:0] gx_r, gy_r;
  logic signed [9:0]  gxx_r, gyy_r;

  always_comb begin
    lft  = has_left_r ? (flush_r ? prev_q : left_centre_r) : ctr_r;
    rgt  = has_right_r ? rgt_r : ctr_r;
    abv  = use_abv_r ? abv_r : ctr_r;
    blw  = flush_r ? ctr_r : gray_r;
    gain = (first_gain_r > 3'd4) ? 4'd4 : {1'b0, first_gain_r};
    gx_full  = $signed({1'b0, gain}) *
               ($signed({6'd0, rgt}) - $signed({6'd0, lft}));
    gy_full  = $signed({1'b0, gain}) *
               ($signed({6'd0, blw}) - $signed({6'd0, abv}));
    gxx_full = $signed({2'd0, ctr_r, 1'b0}) - $signed({3'd0, lft}) - $signed({3'd0, rgt});
    gyy_full = $signed({2'd0, ctr_r, 1'b0}) - $signed({3'd0, abv}) - $signed({3'd0, blw});
    if (abs_enable_r && gx_full[13])  gx_full  = -gx_full;
    if (abs_enable_r && gy_full[13])  gy_full  = -gy_full;
    if (abs_enable_r && gxx_full[10]) gxx_full = -gxx_full;
    if (abs_enable_r && gyy_full[10]) gyy_full = -gyy_full;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      gx_r  <= gx_full[10:0];
      gy_r  <= gy_full[10:0];
      gxx_r <= gxx_full[9:0];
      gyy_r <= gyy_full[9:0];
    end
  end

  // Square root, one result bit per cycle
  logic [SQ_W-1:0] v_r, res_r, bitv;
  logic [SQ_W:0]   trial;
  logic [3:0]      k_r;
  logic [21:0]     sq_x, sq_y;

  always_comb begin
    sq_x  = 22'($signed(gx_r) * $signed(gx_r));
    sq_y  = 22'($signed(gy_r) * $signed(gy_r));
    bitv  = SQ_W'(1) << {k_r, 1'b0};
    trial = {1'b0, res_r} + {1'b0, bitv};
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      v_r   <= SQ_W'(sq_x + sq_y);
      res_r <= '0;
      k_r   <= ROOT_TOP;
    end else if (cmd.root_step) begin
      if ({1'b0, v_r} >= trial) begin
        v_r   <= v_r - trial[SQ_W-1:0];
        res_r <= (res_r >> 1) + bitv;
      end else begin
        res_r <= res_r >> 1;
      end
      k_r <= k_r - 4'd1;
    end
  end

  assign status.skip      = skip;
  assign status.emit      = emit_r;
  assign status.root_done = (k_r == 4'd0);

  assign out_gray_out   = ctr_r;
  assign out_grad_x     = gx_r;
  assign out_grad_y     = gy_r;
  assign out_grad_xx    = gxx_r;
  assign out_grad_yy    = gyy_r;
  assign out_magnitude  = res_r[10:0];
  assign out_frame_last = last_r;

endmodule
